>>> hw/rtl/pbcm_pkg.sv
// Package for the page buffer clock manager: opcodes, result kinds, status codes, states.
package pbcm_pkg;
	localparam int FILE_W = 16;
	localparam int PAGE_W = 31;
	localparam int PINS_W = 16;

	typedef enum logic [2:0] {
		MODE_GET     = 3'd0,
		MODE_ALLOC   = 3'd1,
		MODE_DIRTY   = 3'd2,
		MODE_UNPIN   = 3'd3,
		MODE_FORCE   = 3'd4,
		MODE_FFILE   = 3'd5,
		MODE_FLUSH   = 3'd6,
		MODE_UNUSED  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		KIND_WB   = 2'd0,
		KIND_READ = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_NOPINS  = 2'd2,
		ST_PRESENT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_FREE,
		S_SWEEP,
		S_EVICT,
		S_READ,
		S_WALK,
		S_WALKWB,
		S_OP,
		S_DONE
	} state_t;
endpackage

>>> hw/rtl/pbcm_scan.sv
// Shared slot comparator: tests the slot under the scan index against the current key.
module pbcm_scan #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic                        valid_bit,
	input  logic [pbcm_pkg::FILE_W-1:0] entry_file,
	input  logic [pbcm_pkg::PAGE_W-1:0] entry_page,
	input  logic [pbcm_pkg::FILE_W-1:0] key_file,
	input  logic [pbcm_pkg::PAGE_W-1:0] key_page,
	input  logic [IDX_W-1:0]            idx,
	output logic                        page_hit,
	output logic                        file_hit,
	output logic                        at_end
);
	// One compare per cycle over the scanned slot
	assign file_hit = valid_bit && (entry_file == key_file);
	assign page_hit = file_hit && (entry_page == key_page);
	assign at_end   = (idx == IDX_W'(SLOTS - 1));
endmodule

>>> hw/rtl/page_buffer_clock_manager.sv
// Page buffer clock manager: slot metadata table, sequencer and result register.
// Each request is worked one slot per cycle, with lookups and file walks using a
// single shared comparator; while the output register is stalled, a pending
// writeback waits. Lookup and file walks cover up to SLOTS slots, the free-slot
// search up to SLOTS, and the clock sweep up to SLOTS+1 hand steps. No new
// request is accepted until its completion has been loaded into the output
// register. Results sit in one output register; stall holds it.
module page_buffer_clock_manager #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] file_id,
	input  logic [30:0] page_num,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  slot_index,
	output logic [15:0] out_file,
	output logic [30:0] out_page,
	output logic        fault,
	output logic        pinned_warning,
	output logic [1:0]  status,
	output logic        last
);
	localparam int IDX_W = $clog2(SLOTS);

	// Slot table
	logic [SLOTS-1:0]                  valid_q, dirty_q, ref_q;
	logic [pbcm_pkg::PINS_W-1:0]       pins_q [SLOTS];
	logic [pbcm_pkg::FILE_W-1:0]       file_q [SLOTS];
	logic [pbcm_pkg::PAGE_W-1:0]       page_q [SLOTS];
	logic [IDX_W-1:0]                  hand_q;

	// Request context
	pbcm_pkg::state_t                  state_q, state_d;
	pbcm_pkg::mode_t                   mode_q;
	logic [pbcm_pkg::FILE_W-1:0]       kfile_q;
	logic [pbcm_pkg::PAGE_W-1:0]       kpage_q;
	logic [IDX_W-1:0]                  idx_q, slot_q;
	logic                              warn_q, found_q, nopin_q;

	// Output register
	logic                              ovalid_q;
	pbcm_pkg::kind_t                   okind_q;
	logic [3:0]                        oslot_q;
	logic [15:0]                       ofile_q;
	logic [30:0]                       opage_q;
	logic                              ofault_q, owarn_q, olast_q;
	pbcm_pkg::status_t                 ostat_q;

	logic page_hit, file_hit, at_end, out_free, wb_go;

	pbcm_scan #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_scan (
		.valid_bit (valid_q[idx_q]),
		.entry_file(file_q[idx_q]),
		.entry_page(page_q[idx_q]),
		.key_file  (kfile_q),
		.key_page  (kpage_q),
		.idx       (idx_q),
		.page_hit  (page_hit),
		.file_hit  (file_hit),
		.at_end    (at_end)
	);

	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != pbcm_pkg::S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbcm_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == pbcm_pkg::MODE_FFILE || mode == pbcm_pkg::MODE_FLUSH)
						state_d = pbcm_pkg::S_WALK;
					else if (mode == pbcm_pkg::MODE_UNUSED)
						state_d = pbcm_pkg::S_DONE;
					else
						state_d = pbcm_pkg::S_LOOK;
				end
			end
			pbcm_pkg::S_LOOK: begin
				if (page_hit)
					state_d = pbcm_pkg::S_OP;
				else if (at_end) begin
					if (mode_q == pbcm_pkg::MODE_GET || mode_q == pbcm_pkg::MODE_ALLOC)
						state_d = pbcm_pkg::S_FREE;
					else
						state_d = pbcm_pkg::S_DONE;
				end
			end
			pbcm_pkg::S_FREE: begin
				if (!valid_q[idx_q])
					state_d = (mode_q == pbcm_pkg::MODE_GET) ? pbcm_pkg::S_READ
						: pbcm_pkg::S_DONE;
				else if (at_end)
					state_d = pbcm_pkg::S_SWEEP;
			end
			pbcm_pkg::S_SWEEP: begin
				if (!ref_q[(hand_q == IDX_W'(SLOTS - 1)) ? '0 : hand_q + 1'b1])
					state_d = pbcm_pkg::S_EVICT;
			end
			pbcm_pkg::S_EVICT: begin
				if (!dirty_q[slot_q] || out_free)
					state_d = (mode_q == pbcm_pkg::MODE_GET) ? pbcm_pkg::S_READ
						: pbcm_pkg::S_DONE;
			end
			pbcm_pkg::S_READ: begin
				if (out_free)
					state_d = pbcm_pkg::S_DONE;
			end
			pbcm_pkg::S_WALK: begin
				if (file_hit && dirty_q[idx_q])
					state_d = pbcm_pkg::S_WALKWB;
				else if (at_end)
					state_d = pbcm_pkg::S_DONE;
			end
			pbcm_pkg::S_WALKWB: begin
				if (out_free)
					state_d = at_end ? pbcm_pkg::S_DONE : pbcm_pkg::S_WALK;
			end
			pbcm_pkg::S_OP: begin
				if (mode_q == pbcm_pkg::MODE_FORCE && dirty_q[slot_q]) begin
					if (out_free)
						state_d = pbcm_pkg::S_DONE;
				end else begin
					state_d = pbcm_pkg::S_DONE;
				end
			end
			pbcm_pkg::S_DONE: begin
				if (out_free)
					state_d = pbcm_pkg::S_IDLE;
			end
			default: state_d = pbcm_pkg::S_IDLE;
		endcase
	end

	// Writeback emitted this cycle (eviction, forced page or walk)
	always_comb begin
		wb_go = 1'b0;
		unique case (state_q)
			pbcm_pkg::S_EVICT:  wb_go = dirty_q[slot_q] && out_free;
			pbcm_pkg::S_WALKWB: wb_go = out_free;
			pbcm_pkg::S_OP:     wb_go = mode_q == pbcm_pkg::MODE_FORCE && dirty_q[slot_q]
				&& out_free;
			default:            wb_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pbcm_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Table and context updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ref_q   <= '0;
			for (int i = 0; i < SLOTS; i++)
				pins_q[i] <= '0;
			hand_q  <= IDX_W'(SLOTS - 1);
			idx_q   <= '0;
			slot_q  <= '0;
			warn_q  <= 1'b0;
			found_q <= 1'b0;
			nopin_q <= 1'b0;
			mode_q  <= pbcm_pkg::MODE_GET;
		end else begin
			unique case (state_q)
				pbcm_pkg::S_IDLE: begin
					if (in_valid) begin
						mode_q  <= pbcm_pkg::mode_t'(mode);
						idx_q   <= '0;
						slot_q  <= '0;
						warn_q  <= 1'b0;
						found_q <= 1'b0;
						nopin_q <= 1'b0;
					end
				end
				pbcm_pkg::S_LOOK: begin
					if (page_hit) begin
						slot_q  <= idx_q;
						found_q <= 1'b1;
					end else if (at_end) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				pbcm_pkg::S_FREE: begin
					if (!valid_q[idx_q]) begin
						slot_q <= idx_q;
						valid_q[idx_q] <= 1'b1;
						dirty_q[idx_q] <= 1'b0;
						pins_q[idx_q]  <= 16'd1;
						ref_q[idx_q]   <= 1'b1;
					end else if (!at_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				pbcm_pkg::S_SWEEP: begin
					hand_q <= (hand_q == IDX_W'(SLOTS - 1)) ? '0 : hand_q + 1'b1;
					if (ref_q[(hand_q == IDX_W'(SLOTS - 1)) ? '0 : hand_q + 1'b1])
						ref_q[(hand_q == IDX_W'(SLOTS - 1)) ? '0 : hand_q + 1'b1] <= 1'b0;
					else
						slot_q <= (hand_q == IDX_W'(SLOTS - 1)) ? '0 : hand_q + 1'b1;
				end
				pbcm_pkg::S_EVICT: begin
					if (!dirty_q[slot_q] || out_free) begin
						warn_q <= warn_q | (pins_q[slot_q] != '0);
						valid_q[slot_q] <= 1'b1;
						dirty_q[slot_q] <= 1'b0;
						pins_q[slot_q]  <= 16'd1;
						ref_q[slot_q]   <= 1'b1;
					end
				end
				pbcm_pkg::S_WALK: begin
					if (file_hit) begin
						warn_q <= warn_q | (pins_q[idx_q] != '0);
						if (!dirty_q[idx_q] && mode_q == pbcm_pkg::MODE_FLUSH) begin
							valid_q[idx_q] <= 1'b0;
							pins_q[idx_q]  <= '0;
							ref_q[idx_q]   <= 1'b0;
						end
					end
					if (!(file_hit && dirty_q[idx_q]) && !at_end)
						idx_q <= idx_q + 1'b1;
				end
				pbcm_pkg::S_WALKWB: begin
					if (out_free) begin
						dirty_q[idx_q] <= 1'b0;
						if (mode_q == pbcm_pkg::MODE_FLUSH) begin
							valid_q[idx_q] <= 1'b0;
							pins_q[idx_q]  <= '0;
							ref_q[idx_q]   <= 1'b0;
						end
						if (!at_end)
							idx_q <= idx_q + 1'b1;
					end
				end
				pbcm_pkg::S_OP: begin
					// pin count as found, before any unpin
					nopin_q <= (pins_q[slot_q] == '0);
					unique case (mode_q)
						pbcm_pkg::MODE_GET: begin
							if (pins_q[slot_q] != '1)
								pins_q[slot_q] <= pins_q[slot_q] + 1'b1;
							ref_q[slot_q] <= 1'b1;
						end
						pbcm_pkg::MODE_DIRTY: begin
							if (pins_q[slot_q] != '0)
								dirty_q[slot_q] <= 1'b1;
						end
						pbcm_pkg::MODE_UNPIN: begin
							if (pins_q[slot_q] != '0)
								pins_q[slot_q] <= pins_q[slot_q] - 1'b1;
						end
						pbcm_pkg::MODE_FORCE: begin
							if (!dirty_q[slot_q] || out_free) begin
								warn_q <= pins_q[slot_q] != '0;
								dirty_q[slot_q] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Key and page storage: written on accept and on install
	always_ff @(posedge clk) begin
		if (state_q == pbcm_pkg::S_IDLE && in_valid) begin
			kfile_q <= file_id;
			kpage_q <= page_num;
		end
		if (state_q == pbcm_pkg::S_FREE && !valid_q[idx_q]) begin
			file_q[idx_q] <= kfile_q;
			page_q[idx_q] <= kpage_q;
		end
		if (state_q == pbcm_pkg::S_EVICT && (!dirty_q[slot_q] || out_free)) begin
			file_q[slot_q] <= kfile_q;
			page_q[slot_q] <= kpage_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (wb_go || (out_free && (state_q == pbcm_pkg::S_READ
				|| state_q == pbcm_pkg::S_DONE)))
			ovalid_q <= 1'b1;
		else if (!out_stall)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			okind_q  <= pbcm_pkg::KIND_WB;
			ofault_q <= 1'b0;
			ostat_q  <= pbcm_pkg::ST_OK;
			olast_q  <= 1'b0;
			if (state_q == pbcm_pkg::S_WALKWB) begin
				oslot_q <= 4'(idx_q);
				ofile_q <= file_q[idx_q];
				opage_q <= page_q[idx_q];
				owarn_q <= pins_q[idx_q] != '0;
			end else begin
				oslot_q <= 4'(slot_q);
				ofile_q <= file_q[slot_q];
				opage_q <= page_q[slot_q];
				owarn_q <= pins_q[slot_q] != '0;
			end
		end else if (out_free && state_q == pbcm_pkg::S_READ) begin
			okind_q  <= pbcm_pkg::KIND_READ;
			oslot_q  <= 4'(slot_q);
			ofile_q  <= kfile_q;
			opage_q  <= kpage_q;
			ofault_q <= 1'b0;
			owarn_q  <= 1'b0;
			ostat_q  <= pbcm_pkg::ST_OK;
			olast_q  <= 1'b0;
		end else if (out_free && state_q == pbcm_pkg::S_DONE) begin
			okind_q  <= pbcm_pkg::KIND_DONE;
			olast_q  <= 1'b1;
			ofile_q  <= kfile_q;
			opage_q  <= kpage_q;
			oslot_q  <= 4'(slot_q);
			ofault_q <= 1'b0;
			owarn_q  <= 1'b0;
			ostat_q  <= pbcm_pkg::ST_OK;
			unique case (mode_q)
				pbcm_pkg::MODE_GET, pbcm_pkg::MODE_ALLOC: begin
					if (!found_q) begin
						ofault_q <= 1'b1;
						owarn_q  <= warn_q;
					end else if (mode_q == pbcm_pkg::MODE_ALLOC) begin
						ostat_q <= pbcm_pkg::ST_PRESENT;
					end
				end
				pbcm_pkg::MODE_DIRTY, pbcm_pkg::MODE_UNPIN: begin
					if (!found_q)
						ostat_q <= pbcm_pkg::ST_ABSENT;
					else if (nopin_q)
						ostat_q <= pbcm_pkg::ST_NOPINS;
				end
				pbcm_pkg::MODE_FORCE: begin
					if (!found_q)
						ostat_q <= pbcm_pkg::ST_ABSENT;
					owarn_q <= warn_q;
				end
				pbcm_pkg::MODE_FFILE, pbcm_pkg::MODE_FLUSH: begin
					opage_q <= '0;
					oslot_q <= '0;
					owarn_q <= warn_q;
				end
				default: oslot_q <= '0;
			endcase
		end
	end

	assign out_valid      = ovalid_q;
	assign kind           = okind_q;
	assign slot_index     = oslot_q;
	assign out_file       = ofile_q;
	assign out_page       = opage_q;
	assign fault          = ofault_q;
	assign pinned_warning = owarn_q;
	assign status         = ostat_q;
	assign last           = olast_q;
endmodule

>>> hw/rtl/pbcm_checker.sv
// Port-level checker for the page buffer clock manager, bound to the top level.
module pbcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic        fault,
	input logic        last,
	input logic [1:0]  status
);
	// Only completions close a run
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == pbcm_pkg::KIND_DONE)))
		else $error("last flag disagrees with kind");

	// Requests carry no fault or status
	a_req_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != pbcm_pkg::KIND_DONE |-> !fault && status == pbcm_pkg::ST_OK)
		else $error("request carries completion flags");

	// Busy after accepting a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// Stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind))
		else $error("stalled output changed");
endmodule

bind page_buffer_clock_manager pbcm_checker u_pbcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind     (kind),
	.fault    (fault),
	.last     (last),
	.status   (status)
);
